// ===== src/nss_pkg.sv =====
package nss_pkg;

  localparam int unsigned PhaseW = 3;
  localparam int unsigned ChanW = 4;
  localparam int unsigned FieldW = 16;
  localparam int unsigned LedW = 8;
  localparam int unsigned MuxW = 4;

  localparam logic [PhaseW-1:0] PhNull = 3'd0;
  localparam logic [PhaseW-1:0] Ph730 = 3'd1;
  localparam logic [PhaseW-1:0] Ph850 = 3'd2;
  localparam logic [PhaseW-1:0] PhDark = 3'd3;
  localparam logic [PhaseW-1:0] PhStopped = 3'd4;

  localparam logic ReqCommand = 1'b0;
  localparam logic ReqTick = 1'b1;

  localparam logic [7:0] CmdStart = 8'h73;
  localparam logic [7:0] CmdStop = 8'h70;

  localparam logic [MuxW-1:0] MuxOfChannel [16] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd2, 4'd3, 4'd4, 4'd5,
    4'd4, 4'd5, 4'd6, 4'd7, 4'd6, 4'd7, 4'd9, 4'd11
  };

  function automatic logic [LedW-1:0] drive_for(logic [PhaseW-1:0] ph, logic [ChanW-1:0] ch);
    logic [LedW-1:0] drive;
    drive = '0;
    if (ph == Ph730) begin
      drive = LedW'(1) << {ch[3:2], 1'b0};
    end else if (ph == Ph850) begin
      drive = LedW'(1) << {ch[3:2], 1'b1};
    end
    return drive;
  endfunction

endpackage

// ===== src/nir_scan_sequencer.sv =====
// Result: an accepted item's result is registered into the output register as it is accepted.
// Throughput: one item per cycle; the input is taken whenever the output register
// is empty or its item is being taken in the same cycle.
// Reset: rst_ni clears the output valid, puts the scan in the stopped phase at
// channel 0 and clears both held samples.
module nir_scan_sequencer #(
  parameter int unsigned CHANNELS = 16,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [7:0]  command_byte_i,
  input  logic [15:0] sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  led_drive_o,
  output logic [3:0]  adc_mux_o,
  output logic        report_valid_o,
  output logic [3:0]  report_channel_o,
  output logic [15:0] level_730_o,
  output logic [15:0] level_850_o,
  output logic [15:0] level_dark_o
);

  localparam int unsigned KeepBits = (SAMPLE_BITS < nss_pkg::FieldW) ? SAMPLE_BITS
                                                                     : nss_pkg::FieldW;
  localparam logic [nss_pkg::FieldW-1:0] SampleMask =
    nss_pkg::FieldW'((33'd1 << KeepBits) - 33'd1);
  localparam logic [nss_pkg::ChanW-1:0] LastChannel = nss_pkg::ChanW'(CHANNELS - 1);

  logic [nss_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [nss_pkg::ChanW-1:0]  chan_q, chan_d;
  logic [nss_pkg::FieldW-1:0] held_730_q, held_730_d;
  logic [nss_pkg::FieldW-1:0] held_850_q, held_850_d;

  logic                       out_valid_q;
  logic [nss_pkg::LedW-1:0]   led_q, led_d;
  logic [nss_pkg::MuxW-1:0]   mux_q, mux_d;
  logic                       rv_q, rv_d;
  logic [nss_pkg::ChanW-1:0]  rch_q, rch_d;
  logic [nss_pkg::FieldW-1:0] l730_q, l730_d;
  logic [nss_pkg::FieldW-1:0] l850_q, l850_d;
  logic [nss_pkg::FieldW-1:0] ldark_q, ldark_d;

  logic                       accept;
  logic [nss_pkg::FieldW-1:0] smp;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept = in_valid_i && !in_stall_o;
  assign smp = sample_i & SampleMask;

  always_comb begin
    phase_d = phase_q;
    chan_d = chan_q;
    held_730_d = held_730_q;
    held_850_d = held_850_q;
    rv_d = 1'b0;
    rch_d = '0;
    l730_d = '0;
    l850_d = '0;
    ldark_d = '0;
    if (req_type_i == nss_pkg::ReqCommand) begin
      if (command_byte_i == nss_pkg::CmdStart) begin
        phase_d = nss_pkg::PhDark;
      end else if (command_byte_i == nss_pkg::CmdStop) begin
        phase_d = nss_pkg::PhStopped;
      end
    end else begin
      unique case (phase_q)
        nss_pkg::PhNull: begin
          phase_d = nss_pkg::Ph730;
        end
        nss_pkg::Ph730: begin
          held_730_d = smp;
          phase_d = nss_pkg::Ph850;
        end
        nss_pkg::Ph850: begin
          held_850_d = smp;
          phase_d = nss_pkg::PhDark;
        end
        nss_pkg::PhDark: begin
          rv_d = 1'b1;
          rch_d = chan_q;
          l730_d = held_730_q;
          l850_d = held_850_q;
          ldark_d = smp;
          phase_d = nss_pkg::PhNull;
          if (chan_q >= LastChannel) begin
            chan_d = '0;
          end else begin
            chan_d = chan_q + nss_pkg::ChanW'(1);
          end
        end
        default: begin
        end
      endcase
    end
    led_d = nss_pkg::drive_for(phase_d, chan_d);
    mux_d = nss_pkg::MuxOfChannel[chan_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nss_pkg::PhStopped;
      chan_q <= '0;
      held_730_q <= '0;
      held_850_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        chan_q <= chan_d;
        held_730_q <= held_730_d;
        held_850_q <= held_850_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      led_q <= led_d;
      mux_q <= mux_d;
      rv_q <= rv_d;
      rch_q <= rch_d;
      l730_q <= l730_d;
      l850_q <= l850_d;
      ldark_q <= ldark_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign led_drive_o = led_q;
  assign adc_mux_o = mux_q;
  assign report_valid_o = rv_q;
  assign report_channel_o = rch_q;
  assign level_730_o = l730_q;
  assign level_850_o = l850_q;
  assign level_dark_o = ldark_q;

endmodule
